/* hw/rtl/gcd_pkg.sv */
// Shared types and constants for the greedy convolutional decoder.
`default_nettype none

package gcd_pkg;

  localparam int CODE_W  = 4;   // bits in one received segment
  localparam int TAP_W   = 16;  // width of one tap mask register
  localparam int NUM_TAP = 4;   // tap mask registers provided
  localparam int NADD_W  = 3;   // width of the adder count register
  localparam int LEN_W   = 5;   // width of the register length register
  localparam int ADDR_W  = 5;   // byte address of the config port
  localparam int DATA_W  = 32;  // config port data width

  localparam logic [NADD_W-1:0] NUM_ADDERS_RST = 3'd2;
  localparam logic [LEN_W-1:0]  REG_LEN_RST    = 5'd3;
  localparam logic [TAP_W-1:0]  TAP_ZERO_RST   = 16'h0007;
  localparam logic [TAP_W-1:0]  TAP_ONE_RST    = 16'h0005;
  localparam logic [TAP_W-1:0]  TAP_TWO_RST    = 16'h0000;
  localparam logic [TAP_W-1:0]  TAP_THREE_RST  = 16'h0000;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_NUM_ADDERS,
    REG_REGISTER_LENGTH,
    REG_TAP_MASK_ZERO,
    REG_TAP_MASK_ONE,
    REG_TAP_MASK_TWO,
    REG_TAP_MASK_THREE
  } reg_idx_t;

  typedef struct packed {
    logic [NADD_W-1:0]             num_adders;
    logic [LEN_W-1:0]              register_length;
    logic [NUM_TAP-1:0][TAP_W-1:0] tap_mask;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/gcd_cfg_regs.sv */
// APB-style configuration register bank for the decoder.
`default_nettype none

module gcd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gcd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gcd_pkg::DATA_W-1:0] pwdata,
  output logic      [gcd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output gcd_pkg::cfg_t                   cfg
);
  import gcd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_adders      <= NUM_ADDERS_RST;
      cfg.register_length <= REG_LEN_RST;
      cfg.tap_mask[0]     <= TAP_ZERO_RST;
      cfg.tap_mask[1]     <= TAP_ONE_RST;
      cfg.tap_mask[2]     <= TAP_TWO_RST;
      cfg.tap_mask[3]     <= TAP_THREE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_NUM_ADDERS:      cfg.num_adders      <= pwdata[NADD_W-1:0];
        REG_REGISTER_LENGTH: cfg.register_length <= pwdata[LEN_W-1:0];
        REG_TAP_MASK_ZERO:   cfg.tap_mask[0]     <= pwdata[TAP_W-1:0];
        REG_TAP_MASK_ONE:    cfg.tap_mask[1]     <= pwdata[TAP_W-1:0];
        REG_TAP_MASK_TWO:    cfg.tap_mask[2]     <= pwdata[TAP_W-1:0];
        REG_TAP_MASK_THREE:  cfg.tap_mask[3]     <= pwdata[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUM_ADDERS:      prdata = DATA_W'(cfg.num_adders);
      REG_REGISTER_LENGTH: prdata = DATA_W'(cfg.register_length);
      REG_TAP_MASK_ZERO:   prdata = DATA_W'(cfg.tap_mask[0]);
      REG_TAP_MASK_ONE:    prdata = DATA_W'(cfg.tap_mask[1]);
      REG_TAP_MASK_TWO:    prdata = DATA_W'(cfg.tap_mask[2]);
      REG_TAP_MASK_THREE:  prdata = DATA_W'(cfg.tap_mask[3]);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/gcd_datapath.sv */
// Decoder history register and the combinational greedy bit decision.
`default_nettype none

module gcd_datapath #(
  parameter int MAX_ADDERS = 4,
  parameter int MAX_STAGES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gcd_pkg::cfg_t              cfg,
  input  wire logic [gcd_pkg::CODE_W-1:0] code_bits,
  input  wire logic                       frame_start,
  input  wire logic                       tail_segment,
  input  wire logic                       advance,     // segment leaves the input stage
  output logic                            bit_out
);
  import gcd_pkg::*;

  localparam int HIST_W   = MAX_STAGES;
  localparam int TAP_SPAN = (MAX_STAGES < TAP_W) ? MAX_STAGES : TAP_W;
  localparam int ADD_LIM  = (MAX_ADDERS < NUM_TAP) ? MAX_ADDERS : NUM_TAP;
  localparam int ADD_USED = (ADD_LIM < CODE_W) ? ADD_LIM : CODE_W;
  localparam int WT_W     = $clog2(ADD_USED + 1);

  logic [HIST_W-1:0]   history;
  logic [HIST_W-1:0]   history_next;
  logic [HIST_W-1:0]   base;
  logic [HIST_W-1:0]   stage_mask;
  logic [HIST_W-1:0]   r0;
  logic [ADD_USED-1:0] err0;
  logic [ADD_USED-1:0] err1;
  logic [WT_W-1:0]     w0;
  logic [WT_W-1:0]     w1;
  logic [5:0]          len_ext;

  assign len_ext = {1'b0, cfg.register_length};
  assign base    = frame_start ? '0 : history;

  // Stage 0 is always in use; length beyond the register saturates by width.
  genvar j;
  generate
    for (j = 0; j < HIST_W; j++) begin : g_mask
      if (j == 0) begin : g_first
        assign stage_mask[j] = 1'b1;
      end else begin : g_rest
        assign stage_mask[j] = (len_ext > 6'(j));
      end
    end
  endgenerate

  assign r0 = {base[HIST_W-2:0], 1'b0} & stage_mask;

  // Candidate 1 differs from candidate 0 only at position 0.
  genvar k;
  generate
    for (k = 0; k < ADD_USED; k++) begin : g_adder
      logic p0;
      logic p1;
      logic active;
      assign p0     = ^(r0[TAP_SPAN-1:0] & cfg.tap_mask[k][TAP_SPAN-1:0]);
      assign p1     = p0 ^ cfg.tap_mask[k][0];
      assign active = (cfg.num_adders > NADD_W'(k));
      assign err0[k] = active & (p0 ^ code_bits[k]);
      assign err1[k] = active & (p1 ^ code_bits[k]);
    end
  endgenerate

  always_comb begin
    w0 = '0;
    w1 = '0;
    for (int i = 0; i < ADD_USED; i++) begin
      w0 = w0 + WT_W'(err0[i]);
      w1 = w1 + WT_W'(err1[i]);
    end
  end

  // Tie goes to 0
  assign bit_out = (w1 < w0);

  always_comb begin
    if (tail_segment) begin
      history_next = base;
    end else begin
      history_next = {r0[HIST_W-1:1], bit_out};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (advance) begin
      history <= history_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/greedy_convolutional_decoder_unit.sv */
// Top level of the greedy hard-decision convolutional decoder.
//
// Usage:
//   Input channel: seg_valid / seg_stall carries one received segment per beat
//   (code_bits, frame_start, tail_segment). Output channel: bit_valid /
//   bit_stall carries one decoded_bit per non-tail segment. A beat moves at
//   a rising edge with valid high and stall low.
//   frame_start clears the decoder history before the segment is decided.
//   tail_segment beats produce no output beat and leave history unchanged
//   (apart from the clear requested by frame_start).
//   Path: a segment is captured in the input register at the edge that accepts
//   it, and its decoded bit in the output register once that register is free.
//   Throughput: one segment per cycle while bit_stall is low; the decision and
//   the history update lie combinationally between the input and output
//   registers, so the history feedback loop sets the rate.
//   Stall: while bit_stall holds a result, the next segment waits in the
//   input register and seg_stall rises only when that register is occupied
//   by a segment that would need the output register. Tail beats drain
//   even under output stall.
//   Reset (rst, synchronous): clears both valid flags, the history and
//   restores the configuration registers to their defaults.
//   Config: APB-style writes, register i at byte address 4*i, only while idle.
`default_nettype none

module greedy_convolutional_decoder_unit #(
  parameter int MAX_ADDERS = 4,
  parameter int MAX_STAGES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // config port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gcd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gcd_pkg::DATA_W-1:0] pwdata,
  output logic      [gcd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  // segment channel
  input  wire logic                       seg_valid,
  output logic                            seg_stall,
  input  wire logic [gcd_pkg::CODE_W-1:0] code_bits,
  input  wire logic                       frame_start,
  input  wire logic                       tail_segment,
  // decoded bit channel
  output logic                            bit_valid,
  input  wire logic                       bit_stall,
  output logic                            decoded_bit
);
  import gcd_pkg::*;

  cfg_t              cfg;

  // input register
  logic              s1_valid;
  logic              s1_valid_next;
  logic [CODE_W-1:0] s1_code;
  logic              s1_start;
  logic              s1_tail;

  logic              seg_fire;
  logic              out_free;
  logic              s1_done;
  logic              dec_bit;
  logic              bit_valid_next;

  gcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gcd_datapath #(
    .MAX_ADDERS (MAX_ADDERS),
    .MAX_STAGES (MAX_STAGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .code_bits    (s1_code),
    .frame_start  (s1_start),
    .tail_segment (s1_tail),
    .advance      (s1_done),
    .bit_out      (dec_bit)
  );

  // Output register can take a new beat when empty or being drained now.
  assign out_free = ~bit_valid | ~bit_stall;
  // Tail segments need no output slot.
  assign s1_done   = s1_valid & (s1_tail | out_free);
  assign seg_stall = s1_valid & ~s1_done;
  assign seg_fire  = seg_valid & ~seg_stall;

  assign s1_valid_next  = seg_fire | (s1_valid & ~s1_done);
  assign bit_valid_next = out_free ? (s1_valid & ~s1_tail) : bit_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      bit_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      bit_valid <= bit_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_fire) begin
      s1_code  <= code_bits;
      s1_start <= frame_start;
      s1_tail  <= tail_segment;
    end
    if (out_free & s1_valid & ~s1_tail) begin
      decoded_bit <= dec_bit;
    end
  end

  // A non-tail segment leaving the input stage always lands in the output register.
  a_nontail_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_done & ~s1_tail) |=> bit_valid)
    else $error("non-tail segment did not produce an output beat");

  // Input only backs up behind a held output beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> (s1_valid & ~s1_tail & bit_valid & bit_stall))
    else $error("input stalled without a blocked output");

  // A fresh output beat comes only from a non-tail segment.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(bit_valid) |-> $past(s1_valid & ~s1_tail))
    else $error("output beat without a non-tail source segment");

endmodule

`default_nettype wire
